/* design/lcf_pkg.sv */
// Shared types and constants for the clipped fill command generator.
// No dependencies; imported by every module of the block.
`default_nettype none

package lcf_pkg;

   localparam int DEFAULT_PANEL_WIDTH  = 240;
   localparam int DEFAULT_PANEL_HEIGHT = 320;
   localparam int DEFAULT_QUEUE_DEPTH  = 2;

   localparam logic [7:0] RESET_COL_OPCODE  = 8'h2A;
   localparam logic [7:0] RESET_PAGE_OPCODE = 8'h2B;
   localparam logic [7:0] RESET_RAM_OPCODE  = 8'h2C;

   localparam logic [1:0] CSR_ROTATION  = 2'd0;
   localparam logic [1:0] CSR_COL_OP    = 2'd1;
   localparam logic [1:0] CSR_PAGE_OP   = 2'd2;
   localparam logic [1:0] CSR_RAM_OP    = 2'd3;

   localparam logic [1:0] CMD_PIXEL = 2'd0;
   localparam logic [1:0] CMD_VLINE = 2'd1;
   localparam logic [1:0] CMD_HLINE = 2'd2;
   localparam logic [1:0] CMD_RECT  = 2'd3;

   localparam logic [1:0] KIND_CMD  = 2'd0;
   localparam logic [1:0] KIND_DATA = 2'd1;
   localparam logic [1:0] KIND_RUN  = 2'd2;

   typedef struct packed {
      logic [1:0]         cmd;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic signed [15:0] extent_w;
      logic signed [15:0] extent_h;
      logic [15:0]        color;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] word;
      logic [29:0] run_count;
      logic        last;
   } rsp_payload_type;

   typedef struct packed {
      logic [1:0] rotation;
      logic [7:0] col_opcode;
      logic [7:0] page_opcode;
      logic [7:0] ram_opcode;
   } cfg_type;

   // One clipped request, ready to be sequenced out.
   typedef struct packed {
      logic [15:0] x0;
      logic [15:0] x1;
      logic [15:0] y0;
      logic [15:0] y1;
      logic [15:0] color;
      logic [14:0] count_w;
      logic [14:0] count_h;
   } entry_type;

endpackage

`default_nettype wire

/* design/lcf_front.sv */
// Front end: accepts draw items, clips them against the visible area and
// pushes kept items into the queue. Depends on lcf_pkg.
`default_nettype none

module lcf_front #(
   parameter int PANEL_WIDTH  = lcf_pkg::DEFAULT_PANEL_WIDTH,
   parameter int PANEL_HEIGHT = lcf_pkg::DEFAULT_PANEL_HEIGHT
) (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_valid,
   output logic                   req_stall,
   input  lcf_pkg::req_payload_type req_payload,
   input  lcf_pkg::cfg_type       cfg,
   input  wire                    q_full,
   output logic                   q_push,
   output lcf_pkg::entry_type     q_data
);
   import lcf_pkg::*;

   localparam logic signed [17:0] PW = 18'(PANEL_WIDTH);
   localparam logic signed [17:0] PH = 18'(PANEL_HEIGHT);
   localparam logic signed [17:0] ONE = 18'sd1;
   localparam logic signed [17:0] ZERO = 18'sd0;
   localparam logic signed [17:0] EXT_MAX = 18'sd32767;

   function automatic logic [14:0] sat_count(input logic signed [17:0] e);
      logic [14:0] r;
      if (e <= ZERO) begin
         r = 15'd0;
      end else if (e > EXT_MAX) begin
         r = 15'h7FFF;
      end else begin
         r = e[14:0];
      end
      return r;
   endfunction

   logic signed [17:0] xs, ys, ws, hs, wd, ht;
   logic signed [17:0] x_end, y_end, w_clip, h_clip, x1_clip, y1_clip;
   logic               keep;

   always_comb begin
      xs = {{2{req_payload.pos_x[15]}}, req_payload.pos_x};
      ys = {{2{req_payload.pos_y[15]}}, req_payload.pos_y};
      ws = {{2{req_payload.extent_w[15]}}, req_payload.extent_w};
      hs = {{2{req_payload.extent_h[15]}}, req_payload.extent_h};
      wd = cfg.rotation[0] ? PH : PW;
      ht = cfg.rotation[0] ? PW : PH;

      x_end  = xs + ws - ONE;
      y_end  = ys + hs - ONE;
      w_clip = (x_end >= wd) ? (wd - xs) : ws;
      h_clip = (y_end >= ht) ? (ht - ys) : hs;
      x1_clip = xs + w_clip - ONE;
      y1_clip = ys + h_clip - ONE;

      q_data.x0    = req_payload.pos_x;
      q_data.y0    = req_payload.pos_y;
      q_data.color = req_payload.color;
      keep = (xs < wd) && (ys < ht);

      case (req_payload.cmd)
         CMD_PIXEL: begin
            keep = (xs >= ZERO) && (xs < wd) && (ys >= ZERO) && (ys < ht);
            q_data.x1 = 16'(xs + ONE);
            q_data.y1 = 16'(ys + ONE);
            q_data.count_w = 15'd1;
            q_data.count_h = 15'd1;
         end
         CMD_VLINE: begin
            q_data.x1 = req_payload.pos_x;
            q_data.y1 = y1_clip[15:0];
            q_data.count_w = 15'd1;
            q_data.count_h = sat_count(h_clip);
         end
         CMD_HLINE: begin
            q_data.x1 = x1_clip[15:0];
            q_data.y1 = req_payload.pos_y;
            q_data.count_w = sat_count(w_clip);
            q_data.count_h = 15'd1;
         end
         default: begin
            q_data.x1 = x1_clip[15:0];
            q_data.y1 = y1_clip[15:0];
            q_data.count_w = sat_count(w_clip);
            q_data.count_h = sat_count(h_clip);
         end
      endcase
   end

   assign req_stall = q_full;
   assign q_push    = req_valid && !req_stall && keep;

   assert property (@(posedge clock) disable iff (reset)
      q_push |-> !q_full)
      else $error("push into a full queue");

   assert property (@(posedge clock) disable iff (reset)
      (q_push && req_payload.cmd == CMD_PIXEL) |-> (q_data.count_w == 15'd1 &&
      q_data.count_h == 15'd1))
      else $error("pixel item with count other than one");

   assert property (@(posedge clock) disable iff (reset)
      q_push |-> (q_data.count_w <= 15'h7FFF && (req_valid && !req_stall)))
      else $error("push without an accepted item");

endmodule

`default_nettype wire

/* design/lcf_queue.sv */
// Short FIFO of clipped items between the front end and the sequencer.
// Depends on lcf_pkg for the entry type.
`default_nettype none

module lcf_queue #(
   parameter int DEPTH = lcf_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  wire                clock,
   input  wire                reset,
   input  wire                push,
   input  lcf_pkg::entry_type push_data,
   output logic               full,
   input  wire                pop,
   output lcf_pkg::entry_type pop_data,
   output logic               empty
);
   import lcf_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   entry_type        mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == FULL_CNT);
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_CNT)
      else $error("queue count overflow");

   assert property (@(posedge clock) disable iff (reset)
      (do_push && !do_pop) |=> !empty)
      else $error("queue empty after push");

   assert property (@(posedge clock) disable iff (reset)
      (empty && !do_push) |=> empty)
      else $error("queue filled without push");

endmodule

`default_nettype wire

/* design/lcf_back.sv */
// Back end: takes clipped items from the queue and sends the eight result
// items of each through a registered output. Depends on lcf_pkg.
`default_nettype none

module lcf_back (
   input  wire                     clock,
   input  wire                     reset,
   input  lcf_pkg::cfg_type        cfg,
   input  wire                     q_empty,
   input  lcf_pkg::entry_type      q_data,
   output logic                    q_pop,
   output logic                    rsp_valid,
   input  wire                     rsp_stall,
   output lcf_pkg::rsp_payload_type rsp_payload
);
   import lcf_pkg::*;

   localparam logic [2:0] STEP_COL_CMD    = 3'd0;
   localparam logic [2:0] STEP_COL_START  = 3'd1;
   localparam logic [2:0] STEP_COL_END    = 3'd2;
   localparam logic [2:0] STEP_PAGE_CMD   = 3'd3;
   localparam logic [2:0] STEP_PAGE_START = 3'd4;
   localparam logic [2:0] STEP_PAGE_END   = 3'd5;
   localparam logic [2:0] STEP_RAM_CMD    = 3'd6;
   localparam logic [2:0] STEP_RUN        = 3'd7;

   entry_type       cur_ff, cur_in;
   logic            cur_valid_ff, cur_valid_in;
   logic [2:0]      step_ff, step_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_ff, rsp_in;
   logic            adv, load;

   assign adv   = cur_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign load  = !cur_valid_ff || (adv && step_ff == STEP_RUN);
   assign q_pop = load && !q_empty;

   always_comb begin
      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      step_in      = step_ff;
      if (adv) begin
         step_in = (step_ff == STEP_RUN) ? STEP_COL_CMD : step_ff + 3'd1;
      end
      if (load) begin
         cur_valid_in = !q_empty;
         cur_in       = q_data;
      end
   end

   always_comb begin
      rsp_in = '0;
      case (step_ff)
         STEP_COL_CMD: begin
            rsp_in.kind = KIND_CMD;
            rsp_in.word = {8'd0, cfg.col_opcode};
         end
         STEP_COL_START: begin
            rsp_in.kind = KIND_DATA;
            rsp_in.word = cur_ff.x0;
         end
         STEP_COL_END: begin
            rsp_in.kind = KIND_DATA;
            rsp_in.word = cur_ff.x1;
         end
         STEP_PAGE_CMD: begin
            rsp_in.kind = KIND_CMD;
            rsp_in.word = {8'd0, cfg.page_opcode};
         end
         STEP_PAGE_START: begin
            rsp_in.kind = KIND_DATA;
            rsp_in.word = cur_ff.y0;
         end
         STEP_PAGE_END: begin
            rsp_in.kind = KIND_DATA;
            rsp_in.word = cur_ff.y1;
         end
         STEP_RAM_CMD: begin
            rsp_in.kind = KIND_CMD;
            rsp_in.word = {8'd0, cfg.ram_opcode};
         end
         STEP_RUN: begin
            rsp_in.kind      = KIND_RUN;
            rsp_in.word      = cur_ff.color;
            rsp_in.run_count = {15'd0, cur_ff.count_w} * {15'd0, cur_ff.count_h};
            rsp_in.last      = 1'b1;
         end
         default: begin
            rsp_in = '0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (adv) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         step_ff      <= STEP_COL_CMD;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (adv) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.last) |-> rsp_ff.kind == KIND_RUN)
      else $error("last flag on a non-run item");

   assert property (@(posedge clock) disable iff (reset)
      !cur_valid_ff |-> step_ff == STEP_COL_CMD)
      else $error("sequencer idle in mid-item");

   assert property (@(posedge clock) disable iff (reset)
      (adv && step_ff == STEP_RUN) |=> (rsp_valid_ff && rsp_ff.last))
      else $error("run item not presented");

   assert property (@(posedge clock) disable iff (reset)
      (q_pop && !cur_valid_ff) |=> (cur_valid_ff && step_ff == STEP_COL_CMD))
      else $error("popped item not loaded");

endmodule

`default_nettype wire

/* design/lcd_clipped_fill_command_gen.sv */
// Clipped fill command generator: an accepted item is written into the queue,
// then loaded into the current-item register, and each result is registered.
// The output sequencer sends one result per cycle while the output is not stalled;
// the queue takes new items meanwhile until it is full. Dropped items are not queued.
// Reset is synchronous, active high; registers return to rotation 0 and
// opcodes 0x2A/0x2B/0x2C, queue and sequencer empty.
`default_nettype none

module lcd_clipped_fill_command_gen #(
   parameter int PANEL_WIDTH  = lcf_pkg::DEFAULT_PANEL_WIDTH,
   parameter int PANEL_HEIGHT = lcf_pkg::DEFAULT_PANEL_HEIGHT,
   parameter int QUEUE_DEPTH  = lcf_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   output logic                     req_stall,
   input  lcf_pkg::req_payload_type req_payload,
   output logic                     rsp_valid,
   input  wire                      rsp_stall,
   output lcf_pkg::rsp_payload_type rsp_payload,
   input  wire                      csr_valid,
   output logic                     csr_ready,
   input  wire [1:0]                csr_index,
   input  wire [7:0]                csr_data
);
   import lcf_pkg::*;

   cfg_type   cfg_ff, cfg_in;
   logic      q_full, q_empty, q_push, q_pop;
   entry_type q_wr_data, q_rd_data;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ROTATION: cfg_in.rotation    = csr_data[1:0];
            CSR_COL_OP:   cfg_in.col_opcode  = csr_data;
            CSR_PAGE_OP:  cfg_in.page_opcode = csr_data;
            CSR_RAM_OP:   cfg_in.ram_opcode  = csr_data;
            default:      cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rotation    <= 2'd0;
         cfg_ff.col_opcode  <= RESET_COL_OPCODE;
         cfg_ff.page_opcode <= RESET_PAGE_OPCODE;
         cfg_ff.ram_opcode  <= RESET_RAM_OPCODE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lcf_front #(
      .PANEL_WIDTH (PANEL_WIDTH),
      .PANEL_HEIGHT(PANEL_HEIGHT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_stall  (req_stall),
      .req_payload(req_payload),
      .cfg        (cfg_ff),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_data     (q_wr_data)
   );

   lcf_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_data(q_wr_data),
      .full     (q_full),
      .pop      (q_pop),
      .pop_data (q_rd_data),
      .empty    (q_empty)
   );

   lcf_back u_back (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_empty    (q_empty),
      .q_data     (q_rd_data),
      .q_pop      (q_pop),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .rsp_payload(rsp_payload)
   );

endmodule

`default_nettype wire
